### src/tduart_pkg.sv
// Shared types and constants of the tick-paced 8N1 UART.
// Used by the buffer RAM, the line core, the result buffer and the top level.
`default_nettype none

package tduart_pkg;

  localparam int unsigned DEFAULT_BUFFER_DEPTH = 16;

  localparam int unsigned BIT_TIME_W  = 15;
  localparam int unsigned TICK_STEP_W = 8;
  localparam int unsigned TIMER_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned BIT_POS_W   = 3;

  localparam logic [BIT_TIME_W-1:0]  BIT_TIME_RST  = 15'd104;
  localparam logic [TICK_STEP_W-1:0] TICK_STEP_RST = 8'd1;

  localparam logic [BIT_POS_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic {
    CFG_BIT_TIME  = 1'b0,
    CFG_TICK_STEP = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    TXP_IDLE  = 4'b0001,
    TXP_START = 4'b0010,
    TXP_DATA  = 4'b0100,
    TXP_STOP  = 4'b1000
  } tx_phase_e;

  typedef enum logic [2:0] {
    RXP_START = 3'b001,
    RXP_DATA  = 3'b010,
    RXP_STOP  = 3'b100
  } rx_phase_e;

  typedef struct packed {
    logic [BIT_TIME_W-1:0]  bit_time;
    logic [TICK_STEP_W-1:0] tick_step;
  } cfg_t;

  typedef struct packed {
    logic              tick;
    logic              rx_level;
    logic              rx_start_edge;
    logic              tx_write;
    logic [BYTE_W-1:0] tx_byte;
    logic              rx_read;
    logic              clear_tx_active;
  } item_t;

  typedef struct packed {
    logic               tx_line;
    logic               tx_active;
    logic               rx_active;
    logic [COUNT_W-1:0] rx_count;
    logic [BYTE_W-1:0]  read_data;
    logic               read_valid;
    logic               tx_accepted;
  } rslt_t;

endpackage

`default_nettype wire

### src/tduart_ram.sv
// Byte buffer RAM: one write port, one read port with registered data.
// Write-first on an address collision. Depends on tduart_pkg.
`default_nettype none

module tduart_ram #(
  parameter int unsigned DEPTH = tduart_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire                              clk_i,
  input  wire                              we_i,
  input  wire  [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire  [tduart_pkg::BYTE_W-1:0]    wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [tduart_pkg::BYTE_W-1:0]    rdata_o
);

  logic [tduart_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [tduart_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/tduart_core.sv
// Line core: buffer positions, transmit and receive sequencers, bit timers.
// Holds both byte buffers in tduart_ram with the head entry prefetched. Depends on tduart_pkg.
`default_nettype none

module tduart_core #(
  parameter int unsigned BUFFER_DEPTH = tduart_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_fire_i,
  input  tduart_pkg::item_t         item_i,
  input  tduart_pkg::cfg_t          cfg_i,
  output tduart_pkg::rslt_t         rslt_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CW = (PW > tduart_pkg::COUNT_W) ? PW : tduart_pkg::COUNT_W;
  localparam logic [PW-1:0] DEPTH_POS = PW'(BUFFER_DEPTH);

  logic [PW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic [PW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  tduart_pkg::tx_phase_e tx_phase_q, tx_phase_d;
  tduart_pkg::rx_phase_e rx_phase_q, rx_phase_d;
  logic [tduart_pkg::BIT_POS_W-1:0] tx_bit_q, tx_bit_d, rx_bit_q, rx_bit_d;
  logic [tduart_pkg::TIMER_W-1:0]   tx_timer_q, tx_timer_d, rx_timer_q, rx_timer_d;
  logic [tduart_pkg::BYTE_W-1:0]    rx_shift_q, rx_shift_d;
  logic rx_armed_q, rx_armed_d;
  logic tx_busy_q, tx_busy_d;
  logic rx_busy_q, rx_busy_d;
  logic line_q, line_d;

  logic                           tx_we, rx_we;
  logic [tduart_pkg::BYTE_W-1:0]  tx_rdata, rx_rdata, tx_head;
  logic [tduart_pkg::TIMER_W-1:0] tx_tsum, rx_tsum, bit_lim, half_lim, rx_lim;
  logic [CW-1:0]                  rx_diff;
  logic [tduart_pkg::BYTE_W-1:0]  rd_data;
  logic                           rd_valid, tx_acc;

  tduart_ram #(.DEPTH(BUFFER_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_q[AW-1:0]),
    .wdata_i (item_i.tx_byte),
    .raddr_i (tx_rd_d[AW-1:0]),
    .rdata_o (tx_rdata)
  );

  tduart_ram #(.DEPTH(BUFFER_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_q[AW-1:0]),
    .wdata_i (rx_shift_q),
    .raddr_i (rx_rd_d[AW-1:0]),
    .rdata_o (rx_rdata)
  );

  assign tx_tsum  = tx_timer_q + tduart_pkg::TIMER_W'(cfg_i.tick_step);
  assign rx_tsum  = rx_timer_q + tduart_pkg::TIMER_W'(cfg_i.tick_step);
  assign bit_lim  = tduart_pkg::TIMER_W'(cfg_i.bit_time);
  assign half_lim = (bit_lim + tduart_pkg::TIMER_W'(1)) >> 1;
  assign rx_lim   = ((rx_phase_q == tduart_pkg::RXP_DATA) ||
                     (rx_phase_q == tduart_pkg::RXP_STOP)) ? bit_lim : half_lim;
  assign tx_head  = (tx_we && (tx_wr_q == tx_rd_q)) ? item_i.tx_byte : tx_rdata;

  always_comb begin
    tx_wr_d    = tx_wr_q;
    tx_rd_d    = tx_rd_q;
    rx_wr_d    = rx_wr_q;
    rx_rd_d    = rx_rd_q;
    tx_phase_d = tx_phase_q;
    rx_phase_d = rx_phase_q;
    tx_bit_d   = tx_bit_q;
    rx_bit_d   = rx_bit_q;
    tx_timer_d = tx_timer_q;
    rx_timer_d = rx_timer_q;
    rx_shift_d = rx_shift_q;
    rx_armed_d = rx_armed_q;
    tx_busy_d  = tx_busy_q;
    rx_busy_d  = rx_busy_q;
    line_d     = line_q;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    rd_data    = '0;
    rd_valid   = 1'b0;
    tx_acc     = 1'b0;

    if (in_fire_i) begin
      if (item_i.rx_start_edge) begin
        rx_armed_d = 1'b1;
      end
      if (item_i.clear_tx_active) begin
        tx_busy_d = 1'b0;
      end
      if (item_i.tx_write && (tx_wr_q < DEPTH_POS)) begin
        tx_we   = 1'b1;
        tx_wr_d = tx_wr_q + PW'(1);
        tx_acc  = 1'b1;
      end
      if (item_i.rx_read && (rx_rd_q < rx_wr_q)) begin
        rd_data  = rx_rdata;
        rd_valid = 1'b1;
        rx_rd_d  = rx_rd_q + PW'(1);
      end

      if (item_i.tick) begin
        if (rx_armed_d) begin
          if (rx_tsum < rx_lim) begin
            rx_timer_d = rx_tsum;
          end else begin
            rx_timer_d = '0;
            case (rx_phase_q)
              tduart_pkg::RXP_DATA: begin
                rx_shift_d[rx_bit_q] = rx_shift_q[rx_bit_q] | item_i.rx_level;
                if (rx_bit_q == tduart_pkg::LAST_BIT) begin
                  rx_bit_d   = '0;
                  rx_phase_d = tduart_pkg::RXP_STOP;
                end else begin
                  rx_bit_d = rx_bit_q + tduart_pkg::BIT_POS_W'(1);
                end
              end
              tduart_pkg::RXP_STOP: begin
                rx_busy_d  = 1'b0;
                rx_armed_d = 1'b0;
                if (rx_wr_q < DEPTH_POS) begin
                  rx_we   = 1'b1;
                  rx_wr_d = rx_wr_q + PW'(1);
                end
                rx_phase_d = tduart_pkg::RXP_START;
              end
              default: begin
                rx_busy_d  = 1'b1;
                rx_shift_d = '0;
                rx_phase_d = tduart_pkg::RXP_DATA;
              end
            endcase
          end
        end
        if (rx_wr_d == rx_rd_d) begin
          rx_wr_d = '0;
          rx_rd_d = '0;
        end

        if (tx_tsum < bit_lim) begin
          tx_timer_d = tx_tsum;
        end else begin
          tx_timer_d = '0;
          case (tx_phase_q)
            tduart_pkg::TXP_START: begin
              line_d     = 1'b0;
              tx_busy_d  = 1'b1;
              tx_phase_d = tduart_pkg::TXP_DATA;
            end
            tduart_pkg::TXP_DATA: begin
              line_d = (tx_rd_q < DEPTH_POS) ? tx_head[tx_bit_q] : 1'b0;
              if (tx_bit_q == tduart_pkg::LAST_BIT) begin
                tx_bit_d   = '0;
                tx_phase_d = tduart_pkg::TXP_STOP;
              end else begin
                tx_bit_d = tx_bit_q + tduart_pkg::BIT_POS_W'(1);
              end
            end
            tduart_pkg::TXP_STOP: begin
              line_d     = 1'b1;
              tx_busy_d  = 1'b0;
              tx_rd_d    = tx_rd_q + PW'(1);
              tx_phase_d = tduart_pkg::TXP_IDLE;
            end
            default: begin
              line_d = 1'b1;
              if (tx_wr_d != '0) begin
                tx_phase_d = tduart_pkg::TXP_START;
              end else begin
                tx_phase_d = tduart_pkg::TXP_IDLE;
              end
            end
          endcase
        end
        if (tx_wr_d == tx_rd_d) begin
          tx_wr_d = '0;
          tx_rd_d = '0;
        end
      end
    end
  end

  assign rx_diff = (rx_wr_d >= rx_rd_d) ? (CW'(rx_wr_d) - CW'(rx_rd_d)) : '0;

  assign rslt_o.tx_line     = line_d;
  assign rslt_o.tx_active   = tx_busy_d;
  assign rslt_o.rx_active   = rx_busy_d;
  assign rslt_o.rx_count    = rx_diff[tduart_pkg::COUNT_W-1:0];
  assign rslt_o.read_data   = rd_data;
  assign rslt_o.read_valid  = rd_valid;
  assign rslt_o.tx_accepted = tx_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wr_q    <= '0;
      tx_rd_q    <= '0;
      rx_wr_q    <= '0;
      rx_rd_q    <= '0;
      tx_phase_q <= tduart_pkg::TXP_IDLE;
      rx_phase_q <= tduart_pkg::RXP_START;
      tx_bit_q   <= '0;
      rx_bit_q   <= '0;
      tx_timer_q <= '0;
      rx_timer_q <= '0;
      rx_shift_q <= '0;
      rx_armed_q <= 1'b0;
      tx_busy_q  <= 1'b0;
      rx_busy_q  <= 1'b0;
      line_q     <= 1'b1;
    end else begin
      tx_wr_q    <= tx_wr_d;
      tx_rd_q    <= tx_rd_d;
      rx_wr_q    <= rx_wr_d;
      rx_rd_q    <= rx_rd_d;
      tx_phase_q <= tx_phase_d;
      rx_phase_q <= rx_phase_d;
      tx_bit_q   <= tx_bit_d;
      rx_bit_q   <= rx_bit_d;
      tx_timer_q <= tx_timer_d;
      rx_timer_q <= rx_timer_d;
      rx_shift_q <= rx_shift_d;
      rx_armed_q <= rx_armed_d;
      tx_busy_q  <= tx_busy_d;
      rx_busy_q  <= rx_busy_d;
      line_q     <= line_d;
    end
  end

endmodule

`default_nettype wire

### src/tduart_outbuf.sv
// Two-entry result buffer between the line core and the output channel.
// Keeps input ready a registered signal. Depends on tduart_pkg.
`default_nettype none

module tduart_outbuf (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  tduart_pkg::rslt_t  push_data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  wire                pop_ready_i,
  output tduart_pkg::rslt_t  data_o
);

  tduart_pkg::rslt_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign ready_o = (cnt_q != 2'd2);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### src/tick_driven_uart_8n1.sv
// A result beat is written into the result buffer when its input beat is taken and offered once earlier beats go.
// Throughput: one beat per cycle; input ready falls only while two result beats wait.
// The transmit head byte is prefetched from its buffer RAM, so a data bit needs no wait.
// Reset: asynchronous, active low; positions, sequencers, timers and flags clear,
// registers return to bit_time 104 and tick_step 1; buffer RAM contents stay unset.
// Top level: configuration registers, line core and result buffer. Depends on tduart_pkg.
`default_nettype none

module tick_driven_uart_8n1 #(
  parameter int unsigned BUFFER_DEPTH = tduart_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [14:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         tick_i,
  input  wire         rx_level_i,
  input  wire         rx_start_edge_i,
  input  wire         tx_write_i,
  input  wire  [7:0]  tx_byte_i,
  input  wire         rx_read_i,
  input  wire         clear_tx_active_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        tx_line_o,
  output logic        tx_active_o,
  output logic        rx_active_o,
  output logic [4:0]  rx_count_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic        tx_accepted_o
);

  tduart_pkg::cfg_t  cfg_q, cfg_d;
  tduart_pkg::item_t item;
  tduart_pkg::rslt_t core_rslt, out_rslt;
  logic              in_fire;
  logic              buf_ready;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (tduart_pkg::cfg_reg_e'(cfg_index_i))
        tduart_pkg::CFG_BIT_TIME:  cfg_d.bit_time  = cfg_data_i;
        tduart_pkg::CFG_TICK_STEP: cfg_d.tick_step = cfg_data_i[tduart_pkg::TICK_STEP_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_time  <= tduart_pkg::BIT_TIME_RST;
      cfg_q.tick_step <= tduart_pkg::TICK_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = buf_ready;
  assign in_fire    = in_valid_i && buf_ready;

  assign item.tick            = tick_i;
  assign item.rx_level        = rx_level_i;
  assign item.rx_start_edge   = rx_start_edge_i;
  assign item.tx_write        = tx_write_i;
  assign item.tx_byte         = tx_byte_i;
  assign item.rx_read         = rx_read_i;
  assign item.clear_tx_active = clear_tx_active_i;

  tduart_core #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .rslt_o    (core_rslt)
  );

  tduart_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (core_rslt),
    .ready_o     (buf_ready),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_rslt)
  );

  assign tx_line_o     = out_rslt.tx_line;
  assign tx_active_o   = out_rslt.tx_active;
  assign rx_active_o   = out_rslt.rx_active;
  assign rx_count_o    = out_rslt.rx_count;
  assign read_data_o   = out_rslt.read_data;
  assign read_valid_o  = out_rslt.read_valid;
  assign tx_accepted_o = out_rslt.tx_accepted;

endmodule

`default_nettype wire
